/* rtl/core/bcd_calculator_instruction_executor_defines.svh */
// Assertion macros for the BCD instruction executor.
`ifndef BCD_CALCULATOR_INSTRUCTION_EXECUTOR_DEFINES_SVH
`define BCD_CALCULATOR_INSTRUCTION_EXECUTOR_DEFINES_SVH

// Assert that an implication holds at every edge out of reset.
`define BCE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Assert that a consequence holds in the cycle after an antecedent.
`define BCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/bce_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bce_pkg
// Types and constants shared by the BCD instruction executor.
// ----------------------------------------------------------------------------
package bce_pkg;
    localparam int DIGITS_DEF       = 14;
    localparam int STATUS_COUNT_DEF = 12;
    localparam logic [7:0] ERR_ADDR = 8'd191;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ARITH,
        ST_DONE
    } t_state;

    // arithmetic op codes
    localparam logic [4:0] OP_TSTB   = 5'h00;
    localparam logic [4:0] OP_CLRB   = 5'h01;
    localparam logic [4:0] OP_CMPAC  = 5'h02;
    localparam logic [4:0] OP_TSTCZ  = 5'h03;
    localparam logic [4:0] OP_BTOC   = 5'h04;
    localparam logic [4:0] OP_NEGC0  = 5'h05;
    localparam logic [4:0] OP_CLRC   = 5'h06;
    localparam logic [4:0] OP_NEGC1  = 5'h07;
    localparam logic [4:0] OP_SHLA   = 5'h08;
    localparam logic [4:0] OP_ATOB   = 5'h09;
    localparam logic [4:0] OP_AMCC   = 5'h0A;
    localparam logic [4:0] OP_DECC   = 5'h0B;
    localparam logic [4:0] OP_CTOA   = 5'h0C;
    localparam logic [4:0] OP_TSTC   = 5'h0D;
    localparam logic [4:0] OP_APCC   = 5'h0E;
    localparam logic [4:0] OP_INCC   = 5'h0F;
    localparam logic [4:0] OP_CMPAB  = 5'h10;
    localparam logic [4:0] OP_XBC    = 5'h11;
    localparam logic [4:0] OP_SHRC   = 5'h12;
    localparam logic [4:0] OP_TSTAZ  = 5'h13;
    localparam logic [4:0] OP_SHRB   = 5'h14;
    localparam logic [4:0] OP_DBLC   = 5'h15;
    localparam logic [4:0] OP_SHRA   = 5'h16;
    localparam logic [4:0] OP_CLRA   = 5'h17;
    localparam logic [4:0] OP_AMBA   = 5'h18;
    localparam logic [4:0] OP_XAB    = 5'h19;
    localparam logic [4:0] OP_AMCA   = 5'h1A;
    localparam logic [4:0] OP_DECA   = 5'h1B;
    localparam logic [4:0] OP_APBA   = 5'h1C;
    localparam logic [4:0] OP_XAC    = 5'h1D;
    localparam logic [4:0] OP_APCA   = 5'h1E;
    localparam logic [4:0] OP_INCA   = 5'h1F;

    // unit operation selected per digit
    typedef enum logic [1:0] {
        AU_ADD,
        AU_SUB,
        AU_PASS
    } t_au_op;
endpackage

/* rtl/core/bcd_calculator_instruction_executor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_calculator_instruction_executor
// Executes one 10-bit instruction word of a 14-digit BCD calculator per item.
// ----------------------------------------------------------------------------
// Each accepted instruction is decoded first; arithmetic instructions then
// sweep their digit field one digit per cycle through a single shared BCD
// adder/subtractor (digit order low to high, or high to low for left
// shifts). The result is held in an output register until taken. The next
// item can be accepted as soon as a result has been loaded there; a
// finished item waits in the done state while the previous result has not
// been taken.
module bcd_calculator_instruction_executor #(
    parameter int DIGITS       = bce_pkg::DIGITS_DEF,
    parameter int STATUS_COUNT = bce_pkg::STATUS_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [9:0]            i_instr_word,
    input  logic                  i_key_valid,
    input  logic [7:0]            i_key_value,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [7:0]            o_next_addr,
    output logic [2:0]            o_next_bank,
    output logic                  o_error_flag,
    output logic                  o_display_on,
    output logic                  o_display_strobe,
    output logic [4*DIGITS-1:0]   o_digits_a,
    output logic [4*DIGITS-1:0]   o_digits_b
);
    import bce_pkg::*;

    localparam int DW = 4 * DIGITS;

    t_state r_state, n_state;

    logic [DW-1:0] r_a, r_b, r_c, r_d, r_e, r_f, r_m;
    logic [DW-1:0] n_a, n_b, n_c, n_d, n_e, n_f, n_m;
    logic [15:0]   r_st, n_st;
    logic [3:0]    r_p, n_p;
    logic          r_cy, n_cy, r_cyb, n_cyb;
    logic [7:0]    r_pc, n_pc, r_ret, n_ret, r_key, n_key;
    logic [2:0]    r_bank, n_bank;
    logic          r_disp, n_disp, r_pend, n_pend, r_err, n_err;
    logic [9:0]    r_iw;
    logic          r_kv;
    logic [7:0]    r_kval;
    logic [3:0]    r_idx, n_idx, r_hi, n_hi, r_lo, n_lo;
    logic [4:0]    r_op, n_op;
    logic          r_down, n_down;

    logic          r_ovalid, n_ovalid;
    logic          r_strobe, n_strobe;
    logic [DW-1:0] r_oa, n_oa, r_ob, n_ob;
    logic [7:0]    r_oaddr, n_oaddr;
    logic [2:0]    r_obank, n_obank;
    logic          r_oerr, n_oerr, r_odisp, n_odisp;

    // shared digit unit
    t_au_op        au_op;
    logic [3:0]    au_x, au_y, au_r;
    logic          au_ci, au_co;
    logic [5:0]    au_sum;

    logic [1:0] h;
    logic [7:0] l;
    logic [3:0] sidx;
    logic [2:0] sel;
    logic       acc;

    assign h    = r_iw[9:8];
    assign l    = r_iw[7:0];
    assign sidx = {h, l[7:6]};
    assign sel  = {h, l[7]};
    assign acc  = i_valid && o_ready;

    function automatic logic [3:0] dig(input logic [DW-1:0] v, input logic [3:0] i);
        dig = v[4*i +: 4];
    endfunction

    always_comb begin
        au_sum = 6'd0;
        au_r   = au_x;
        au_co  = 1'b0;
        case (au_op)
            AU_ADD: begin
                au_sum = {2'b00, au_x} + {2'b00, au_y} + {5'd0, au_ci};
                if (au_sum > 6'd9) begin
                    au_sum = au_sum - 6'd10;
                    au_co  = 1'b1;
                end
                au_r = au_sum[3:0];
            end
            AU_SUB: begin
                au_sum = {2'b00, au_x} - {2'b00, au_y} - {5'd0, au_ci};
                if (au_sum[5]) begin
                    au_sum = au_sum + 6'd10;
                    au_co  = 1'b1;
                end
                au_r = au_sum[3:0];
            end
            default: begin
                au_r  = au_x;
                au_co = au_ci;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (acc) n_state = ST_DECODE;
            ST_DECODE: n_state = (l[1:0] == 2'b10 && n_lo <= n_hi) ? ST_ARITH : ST_DONE;
            ST_ARITH:  if ((r_down ? r_idx == r_lo : r_idx == r_hi)) n_state = ST_DONE;
            ST_DONE:   if (!r_ovalid || i_ready) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        logic [3:0] da, db, dc;
        logic [3:0] k;
        n_a = r_a; n_b = r_b; n_c = r_c; n_d = r_d; n_e = r_e; n_f = r_f; n_m = r_m;
        n_st = r_st; n_p = r_p; n_cy = r_cy; n_cyb = r_cyb; n_pc = r_pc;
        n_ret = r_ret; n_key = r_key; n_bank = r_bank; n_disp = r_disp;
        n_pend = r_pend; n_err = r_err; n_idx = r_idx; n_hi = r_hi; n_lo = r_lo;
        n_op = r_op; n_down = r_down;
        n_ovalid = r_ovalid; n_strobe = r_strobe; n_oa = r_oa; n_ob = r_ob;
        n_oaddr = r_oaddr; n_obank = r_obank; n_oerr = r_oerr; n_odisp = r_odisp;
        au_op = AU_PASS; au_x = 4'd0; au_y = 4'd0; au_ci = r_cy;
        da = dig(r_a, r_idx); db = dig(r_b, r_idx); dc = dig(r_c, r_idx);
        k = 4'd0;

        if (r_ovalid && i_ready) n_ovalid = 1'b0;

        case (r_state)
            ST_DECODE: begin
                if (r_pc == ERR_ADDR && r_bank == 3'd0) n_err = 1'b1;
                n_cyb = r_cy;
                n_cy  = 1'b0;
                n_pc  = r_pc + 8'd1;
                if (r_kv) begin
                    n_err   = 1'b0;
                    n_key   = r_kval;
                    n_st[0] = 1'b1;
                end
                if (l[1:0] == 2'b01) begin
                    n_ret = n_pc;
                    n_pc  = {h, l[7:2]};
                end
                if (l[6:0] == 7'h30) n_pc = r_ret;
                if (l[6:0] == 7'h10) n_bank = {h, l[7]};
                if (l == 8'hD0) begin
                    n_pc    = n_key;
                    n_st[0] = 1'b0;
                end
                if (l[5:0] == 6'h14)
                    n_cy = (32'(sidx) < STATUS_COUNT) ? n_st[sidx] : 1'b0;
                if (l[5:0] == 6'h04 && 32'(sidx) < STATUS_COUNT) n_st[sidx] = 1'b1;
                if (l[5:0] == 6'h24 && 32'(sidx) < STATUS_COUNT) n_st[sidx] = 1'b0;
                if (l[5:0] == 6'h34) n_st = '0;
                if (l[5:0] == 6'h2C) n_cy = (r_p == sidx);
                if (l[5:0] == 6'h0C) n_p = sidx;
                if (l[5:0] == 6'h3C) n_p = r_p + 4'd1;
                if (l[5:0] == 6'h1C) n_p = r_p - 4'd1;
                if (l[5:0] == 6'h18) begin
                    if (32'(r_p) < DIGITS) n_c[4*r_p +: 4] = sidx;
                    n_p = r_p - 4'd1;
                end
                if ((l & 8'hEF) == 8'hA8 || (l & 8'hEF) == 8'h28) begin
                    case (sel)
                        3'd1: begin n_c = r_m; n_m = r_c; end
                        3'd2: begin n_f = r_e; n_e = r_d; n_d = r_c; end
                        3'd3: begin n_a = r_d; n_d = r_e; n_e = r_f; end
                        3'd5: n_c = r_m;
                        3'd6: begin n_c = r_d; n_d = r_e; n_e = r_f; n_f = r_c; end
                        3'd7: begin
                            n_a = '0; n_b = '0; n_c = '0; n_d = '0;
                            n_e = '0; n_f = '0; n_m = '0;
                        end
                        3'd0: begin n_disp = 1'b0; n_pend = 1'b0; end
                        3'd4: begin
                            n_disp = ~r_disp;
                            if (!r_disp) n_pend = 1'b1;
                        end
                        default: ;
                    endcase
                end
                if (l[1:0] == 2'b11 && !n_cyb) n_pc = {h, l[7:2]};
                n_op = {h, l[7:5]};
                case (l[4:2])
                    3'd0: begin
                        n_lo = r_p; n_hi = r_p;
                        if (32'(r_p) >= DIGITS) begin n_lo = 4'd1; n_hi = 4'd0; end
                    end
                    3'd1: begin n_lo = 4'd3; n_hi = 4'(DIGITS - 2); end
                    3'd2: begin n_lo = 4'd0; n_hi = 4'd2; end
                    3'd3: begin n_lo = 4'd0; n_hi = 4'(DIGITS - 1); end
                    3'd4: begin
                        n_lo = 4'd0;
                        n_hi = (32'(r_p) < DIGITS) ? r_p : 4'(DIGITS - 1);
                    end
                    3'd5: begin n_lo = 4'd3; n_hi = 4'(DIGITS - 1); end
                    3'd6: begin n_lo = 4'd2; n_hi = 4'd2; end
                    default: begin n_lo = 4'(DIGITS - 1); n_hi = 4'(DIGITS - 1); end
                endcase
                n_down = (n_op == OP_SHLA);
                n_idx  = n_down ? n_hi : n_lo;
                if (l[1:0] == 2'b10) begin
                    case (n_op)
                        OP_TSTCZ, OP_NEGC1, OP_DECC, OP_INCC, OP_TSTAZ, OP_DECA, OP_INCA:
                            n_cy = 1'b1;
                        default: n_cy = 1'b0;
                    endcase
                end
            end
            ST_ARITH: begin
                if (r_down) n_idx = r_idx - 4'd1;
                else        n_idx = r_idx + 4'd1;
                k = r_idx + 4'd1;
                case (r_op)
                    OP_TSTB:  if (db != 4'd0) n_cy = 1'b1;
                    OP_CLRB:  n_b[4*r_idx +: 4] = 4'd0;
                    OP_CMPAC: begin au_op = AU_SUB; au_x = da; au_y = dc; n_cy = au_co; end
                    OP_TSTCZ: if (dc != 4'd0) n_cy = 1'b0;
                    OP_BTOC:  n_c[4*r_idx +: 4] = db;
                    OP_NEGC0, OP_NEGC1: begin
                        au_op = AU_SUB; au_x = 4'd0; au_y = dc;
                        n_c[4*r_idx +: 4] = au_r; n_cy = au_co;
                    end
                    OP_CLRC:  n_c[4*r_idx +: 4] = 4'd0;
                    OP_SHLA:  n_a[4*r_idx +: 4] = (r_idx == r_lo) ? 4'd0 : dig(r_a, r_idx - 4'd1);
                    OP_ATOB:  n_b[4*r_idx +: 4] = da;
                    OP_AMCC: begin
                        au_op = AU_SUB; au_x = da; au_y = dc;
                        n_c[4*r_idx +: 4] = au_r; n_cy = au_co;
                    end
                    OP_DECC: begin
                        au_op = AU_SUB; au_x = dc; au_y = 4'd0;
                        n_c[4*r_idx +: 4] = au_r; n_cy = au_co;
                    end
                    OP_CTOA:  n_a[4*r_idx +: 4] = dc;
                    OP_TSTC:  if (dc != 4'd0) n_cy = 1'b1;
                    OP_APCC: begin
                        au_op = AU_ADD; au_x = da; au_y = dc;
                        n_c[4*r_idx +: 4] = au_r; n_cy = au_co;
                    end
                    OP_INCC: begin
                        au_op = AU_ADD; au_x = dc; au_y = 4'd0;
                        n_c[4*r_idx +: 4] = au_r; n_cy = au_co;
                    end
                    OP_CMPAB: begin au_op = AU_SUB; au_x = da; au_y = db; n_cy = au_co; end
                    OP_XBC: begin n_b[4*r_idx +: 4] = dc; n_c[4*r_idx +: 4] = db; end
                    OP_SHRC:  n_c[4*r_idx +: 4] = (r_idx == r_hi) ? 4'd0 : dig(r_c, k);
                    OP_TSTAZ: if (da != 4'd0) n_cy = 1'b0;
                    OP_SHRB:  n_b[4*r_idx +: 4] = (r_idx == r_hi) ? 4'd0 : dig(r_b, k);
                    OP_DBLC: begin
                        au_op = AU_ADD; au_x = dc; au_y = dc;
                        n_c[4*r_idx +: 4] = au_r; n_cy = au_co;
                    end
                    OP_SHRA:  n_a[4*r_idx +: 4] = (r_idx == r_hi) ? 4'd0 : dig(r_a, k);
                    OP_CLRA:  n_a[4*r_idx +: 4] = 4'd0;
                    OP_AMBA: begin
                        au_op = AU_SUB; au_x = da; au_y = db;
                        n_a[4*r_idx +: 4] = au_r; n_cy = au_co;
                    end
                    OP_XAB: begin n_a[4*r_idx +: 4] = db; n_b[4*r_idx +: 4] = da; end
                    OP_AMCA: begin
                        au_op = AU_SUB; au_x = da; au_y = dc;
                        n_a[4*r_idx +: 4] = au_r; n_cy = au_co;
                    end
                    OP_DECA: begin
                        au_op = AU_SUB; au_x = da; au_y = 4'd0;
                        n_a[4*r_idx +: 4] = au_r; n_cy = au_co;
                    end
                    OP_APBA: begin
                        au_op = AU_ADD; au_x = da; au_y = db;
                        n_a[4*r_idx +: 4] = au_r; n_cy = au_co;
                    end
                    OP_XAC: begin n_a[4*r_idx +: 4] = dc; n_c[4*r_idx +: 4] = da; end
                    OP_APCA: begin
                        au_op = AU_ADD; au_x = da; au_y = dc;
                        n_a[4*r_idx +: 4] = au_r; n_cy = au_co;
                    end
                    default: begin
                        au_op = AU_ADD; au_x = da; au_y = 4'd0;
                        n_a[4*r_idx +: 4] = au_r; n_cy = au_co;
                    end
                endcase
            end
            ST_DONE: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_strobe = 1'b0;
                    n_oa     = '0;
                    n_ob     = '0;
                    n_oaddr  = r_pc;
                    n_obank  = r_bank;
                    n_oerr   = r_err;
                    n_odisp  = r_disp;
                    if (r_disp) n_pend = 1'b1;
                    else if (r_pend) begin
                        n_strobe = 1'b1;
                        n_pend   = 1'b0;
                        n_oa     = r_a;
                        n_ob     = r_b;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_a <= '0; r_b <= '0; r_c <= '0; r_d <= '0; r_e <= '0; r_f <= '0; r_m <= '0;
            r_st <= '0; r_p <= '0; r_cy <= 1'b0; r_cyb <= 1'b0; r_pc <= '0;
            r_ret <= '0; r_key <= '0; r_bank <= '0; r_disp <= 1'b0;
            r_pend <= 1'b0; r_err <= 1'b0; r_ovalid <= 1'b0; r_strobe <= 1'b0;
            r_oaddr <= '0; r_obank <= '0; r_oerr <= 1'b0; r_odisp <= 1'b0;
        end else begin
            r_state <= n_state;
            r_a <= n_a; r_b <= n_b; r_c <= n_c; r_d <= n_d; r_e <= n_e; r_f <= n_f;
            r_m <= n_m; r_st <= n_st; r_p <= n_p; r_cy <= n_cy; r_cyb <= n_cyb;
            r_pc <= n_pc; r_ret <= n_ret; r_key <= n_key; r_bank <= n_bank;
            r_disp <= n_disp; r_pend <= n_pend; r_err <= n_err;
            r_ovalid <= n_ovalid; r_strobe <= n_strobe;
            r_oaddr <= n_oaddr; r_obank <= n_obank; r_oerr <= n_oerr; r_odisp <= n_odisp;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_iw   <= i_instr_word;
            r_kv   <= i_key_valid;
            r_kval <= i_key_value;
        end
        r_idx <= n_idx; r_hi <= n_hi; r_lo <= n_lo; r_op <= n_op; r_down <= n_down;
        r_oa <= n_oa; r_ob <= n_ob;
    end

    assign o_ready          = (r_state == ST_IDLE);
    assign o_valid          = r_ovalid;
    assign o_next_addr      = r_oaddr;
    assign o_next_bank      = r_obank;
    assign o_error_flag     = r_oerr;
    assign o_display_on     = r_odisp;
    assign o_display_strobe = r_strobe;
    assign o_digits_a       = r_oa;
    assign o_digits_b       = r_ob;
endmodule

/* rtl/core/bce_checker.sv */
`timescale 1ns / 1ps
`include "bcd_calculator_instruction_executor_defines.svh"
// ----------------------------------------------------------------------------
// bce_checker
// Port-level checks for the BCD instruction executor.
// ----------------------------------------------------------------------------
module bce_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [7:0]  o_next_addr,
    input logic        o_display_on,
    input logic        o_display_strobe,
    input logic [55:0] o_digits_a
);
    // a transfer in starts work, so the block goes busy
    `BCE_ASSERT_NEXT(a_busy, i_clk, i_rst_n, i_valid && o_ready, !o_ready, "not busy after transfer")
    // result held while stalled
    `BCE_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_next_addr), "result dropped")
    // strobe only with display off
    `BCE_ASSERT_IMPL(a_strb, i_clk, i_rst_n, o_valid && o_display_strobe, !o_display_on, "strobe with display on")
    // digits are zero without strobe
    `BCE_ASSERT_IMPL(a_zero, i_clk, i_rst_n, o_valid && !o_display_strobe, o_digits_a == 56'd0, "digits without strobe")
endmodule

bind bcd_calculator_instruction_executor bce_checker u_bce_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_next_addr(o_next_addr),
    .o_display_on(o_display_on), .o_display_strobe(o_display_strobe),
    .o_digits_a(o_digits_a)
);

/* verif/bcd_calculator_instruction_executor_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_calculator_instruction_executor_tb
// Drives instruction words with random key presses through the executor and
// checks every result against a cycle-free model of the calculator core.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [7:0]  next_addr;
    logic [2:0]  next_bank;
    logic        error_flag;
    logic        display_on;
    logic        display_strobe;
    logic [55:0] digits_a;
    logic [55:0] digits_b;
} t_exec_result;

class exec_scoreboard;
    localparam int ND = 14;
    localparam int NS = 12;

    logic [3:0] ra[ND], rb[ND], rc[ND], sd[ND], se[ND], sf[ND], mm[ND];
    logic       flags[16];
    logic [3:0] ptr;
    logic       cy, cy_prev;
    logic [7:0] pc, ret_pc, key_latch;
    logic [2:0] bank;
    logic       disp_en, disp_pend, err;
    t_exec_result pending_q[$];
    int unsigned  mismatches;

    function new();
        foreach (ra[i]) begin
            ra[i] = 0; rb[i] = 0; rc[i] = 0; sd[i] = 0; se[i] = 0; sf[i] = 0; mm[i] = 0;
        end
        foreach (flags[i]) flags[i] = 0;
        ptr = 0; cy = 0; cy_prev = 0; pc = 0; ret_pc = 0; key_latch = 0;
        bank = 0; disp_en = 0; disp_pend = 0; err = 0;
        mismatches = 0;
    endfunction

    function logic [3:0] dadd(logic [3:0] x, logic [3:0] y);
        int r;
        r = int'(x) + int'(y) + int'(cy);
        if (r > 9) begin
            r -= 10; cy = 1;
        end else begin
            cy = 0;
        end
        return r[3:0];
    endfunction

    function logic [3:0] dsub(logic [3:0] x, logic [3:0] y);
        int r;
        r = int'(x) - int'(y) - int'(cy);
        if (r < 0) begin
            r += 10; cy = 1;
        end else begin
            cy = 0;
        end
        return r[3:0];
    endfunction

    function void run_field_op(logic [4:0] op, int lo, int hi);
        logic [3:0] t;
        logic [3:0] dummy;
        cy = 0;
        case (op)
            bce_pkg::OP_TSTB:  for (int i = lo; i <= hi; i++) if (rb[i] != 0) cy = 1;
            bce_pkg::OP_CLRB:  for (int i = lo; i <= hi; i++) rb[i] = 0;
            bce_pkg::OP_CMPAC: for (int i = lo; i <= hi; i++) dummy = dsub(ra[i], rc[i]);
            bce_pkg::OP_TSTCZ: begin
                cy = 1;
                for (int i = lo; i <= hi; i++) if (rc[i] != 0) cy = 0;
            end
            bce_pkg::OP_BTOC:  for (int i = lo; i <= hi; i++) rc[i] = rb[i];
            bce_pkg::OP_NEGC0: for (int i = lo; i <= hi; i++) rc[i] = dsub(0, rc[i]);
            bce_pkg::OP_CLRC:  for (int i = lo; i <= hi; i++) rc[i] = 0;
            bce_pkg::OP_NEGC1: begin
                cy = 1;
                for (int i = lo; i <= hi; i++) rc[i] = dsub(0, rc[i]);
            end
            bce_pkg::OP_SHLA: if (lo <= hi) begin
                for (int i = hi; i > lo; i--) ra[i] = ra[i-1];
                ra[lo] = 0;
            end
            bce_pkg::OP_ATOB:  for (int i = lo; i <= hi; i++) rb[i] = ra[i];
            bce_pkg::OP_AMCC:  for (int i = lo; i <= hi; i++) rc[i] = dsub(ra[i], rc[i]);
            bce_pkg::OP_DECC: begin
                cy = 1;
                for (int i = lo; i <= hi; i++) rc[i] = dsub(rc[i], 0);
            end
            bce_pkg::OP_CTOA:  for (int i = lo; i <= hi; i++) ra[i] = rc[i];
            bce_pkg::OP_TSTC:  for (int i = lo; i <= hi; i++) if (rc[i] != 0) cy = 1;
            bce_pkg::OP_APCC:  for (int i = lo; i <= hi; i++) rc[i] = dadd(ra[i], rc[i]);
            bce_pkg::OP_INCC: begin
                cy = 1;
                for (int i = lo; i <= hi; i++) rc[i] = dadd(rc[i], 0);
            end
            bce_pkg::OP_CMPAB: for (int i = lo; i <= hi; i++) dummy = dsub(ra[i], rb[i]);
            bce_pkg::OP_XBC: for (int i = lo; i <= hi; i++) begin
                t = rb[i]; rb[i] = rc[i]; rc[i] = t;
            end
            bce_pkg::OP_SHRC: if (lo <= hi) begin
                for (int i = lo; i < hi; i++) rc[i] = rc[i+1];
                rc[hi] = 0;
            end
            bce_pkg::OP_TSTAZ: begin
                cy = 1;
                for (int i = lo; i <= hi; i++) if (ra[i] != 0) cy = 0;
            end
            bce_pkg::OP_SHRB: if (lo <= hi) begin
                for (int i = lo; i < hi; i++) rb[i] = rb[i+1];
                rb[hi] = 0;
            end
            bce_pkg::OP_DBLC:  for (int i = lo; i <= hi; i++) rc[i] = dadd(rc[i], rc[i]);
            bce_pkg::OP_SHRA: if (lo <= hi) begin
                for (int i = lo; i < hi; i++) ra[i] = ra[i+1];
                ra[hi] = 0;
            end
            bce_pkg::OP_CLRA:  for (int i = lo; i <= hi; i++) ra[i] = 0;
            bce_pkg::OP_AMBA:  for (int i = lo; i <= hi; i++) ra[i] = dsub(ra[i], rb[i]);
            bce_pkg::OP_XAB: for (int i = lo; i <= hi; i++) begin
                t = ra[i]; ra[i] = rb[i]; rb[i] = t;
            end
            bce_pkg::OP_AMCA:  for (int i = lo; i <= hi; i++) ra[i] = dsub(ra[i], rc[i]);
            bce_pkg::OP_DECA: begin
                cy = 1;
                for (int i = lo; i <= hi; i++) ra[i] = dsub(ra[i], 0);
            end
            bce_pkg::OP_APBA:  for (int i = lo; i <= hi; i++) ra[i] = dadd(ra[i], rb[i]);
            bce_pkg::OP_XAC: for (int i = lo; i <= hi; i++) begin
                t = ra[i]; ra[i] = rc[i]; rc[i] = t;
            end
            bce_pkg::OP_APCA:  for (int i = lo; i <= hi; i++) ra[i] = dadd(ra[i], rc[i]);
            default: begin
                cy = 1;
                for (int i = lo; i <= hi; i++) ra[i] = dadd(ra[i], 0);
            end
        endcase
    endfunction

    function logic [55:0] pack_reg(logic [3:0] r[ND]);
        logic [55:0] v;
        for (int i = 0; i < ND; i++) v[4*i +: 4] = r[i];
        return v;
    endfunction

    // Execute one word and queue the result it must produce.
    function void note_transfer(logic [9:0] word, logic kv, logic [7:0] kval);
        logic [1:0] h;
        logic [7:0] l;
        logic [3:0] sidx;
        logic [2:0] sel;
        logic [3:0] t;
        logic       strobe;
        int lo, hi;
        t_exec_result res;
        h = word[9:8]; l = word[7:0];
        sidx = {h, l[7:6]};
        strobe = 0;
        if (pc == bce_pkg::ERR_ADDR && bank == 0) err = 1;
        cy_prev = cy; cy = 0; pc = pc + 8'd1;
        if (kv) begin
            err = 0; key_latch = kval; flags[0] = 1;
        end
        if (l[1:0] == 2'b01) begin
            ret_pc = pc; pc = {h, l[7:2]};
        end
        if (l[6:0] == 7'h30) pc = ret_pc;
        if (l[6:0] == 7'h10) bank = {h, l[7]};
        if (l == 8'hD0) begin
            pc = key_latch; flags[0] = 0;
        end
        if (l[5:0] == 6'h14) cy = (sidx < NS) ? flags[sidx] : 1'b0;
        if (l[5:0] == 6'h04 && sidx < NS) flags[sidx] = 1;
        if (l[5:0] == 6'h24 && sidx < NS) flags[sidx] = 0;
        if (l[5:0] == 6'h34) for (int i = 0; i < NS; i++) flags[i] = 0;
        if (l[5:0] == 6'h2C) cy = (ptr == sidx);
        if (l[5:0] == 6'h0C) ptr = sidx;
        if (l[5:0] == 6'h3C) ptr = ptr + 4'd1;
        if (l[5:0] == 6'h1C) ptr = ptr - 4'd1;
        if (l[5:0] == 6'h18) begin
            if (ptr < ND) rc[ptr] = sidx;
            ptr = ptr - 4'd1;
        end
        if ((l & 8'hEF) == 8'hA8 || (l & 8'hEF) == 8'h28) begin
            sel = {h, l[7]};
            for (int i = 0; i < ND; i++) begin
                case (sel)
                    3'd1: begin t = rc[i]; rc[i] = mm[i]; mm[i] = t; end
                    3'd2: begin sf[i] = se[i]; se[i] = sd[i]; sd[i] = rc[i]; end
                    3'd3: begin ra[i] = sd[i]; sd[i] = se[i]; se[i] = sf[i]; end
                    3'd5: rc[i] = mm[i];
                    3'd6: begin
                        t = rc[i]; rc[i] = sd[i]; sd[i] = se[i]; se[i] = sf[i]; sf[i] = t;
                    end
                    3'd7: begin
                        ra[i] = 0; rb[i] = 0; rc[i] = 0; sd[i] = 0;
                        se[i] = 0; sf[i] = 0; mm[i] = 0;
                    end
                    default: ;
                endcase
            end
            if (sel == 3'd0) begin
                disp_en = 0; disp_pend = 0;
            end
            if (sel == 3'd4) begin
                disp_en = ~disp_en;
                if (disp_en) disp_pend = 1;
            end
        end
        if (l[1:0] == 2'b11 && cy_prev != 1) pc = {h, l[7:2]};
        if (l[1:0] == 2'b10) begin
            case (l[4:2])
                3'd0: if (ptr < ND) begin
                    lo = ptr; hi = ptr;
                end else begin
                    lo = 1; hi = 0;
                end
                3'd1: begin lo = 3; hi = ND - 2; end
                3'd2: begin lo = 0; hi = 2; end
                3'd3: begin lo = 0; hi = ND - 1; end
                3'd4: begin lo = 0; hi = (ptr < ND) ? int'(ptr) : ND - 1; end
                3'd5: begin lo = 3; hi = ND - 1; end
                3'd6: begin lo = 2; hi = 2; end
                default: begin lo = ND - 1; hi = ND - 1; end
            endcase
            run_field_op({h, l[7:5]}, lo, hi);
        end
        if (disp_en) begin
            disp_pend = 1;
        end else if (disp_pend) begin
            strobe = 1; disp_pend = 0;
        end
        res.next_addr = pc;
        res.next_bank = bank;
        res.error_flag = err;
        res.display_on = disp_en;
        res.display_strobe = strobe;
        res.digits_a = strobe ? pack_reg(ra) : 56'd0;
        res.digits_b = strobe ? pack_reg(rb) : 56'd0;
        pending_q.push_back(res);
    endfunction

    function void check_result(t_exec_result got);
        t_exec_result exp_r;
        if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("ERROR: unexpected result %h", got);
            return;
        end
        exp_r = pending_q.pop_front();
        if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: addr %h/%h bank %h/%h err %b/%b disp %b/%b strb %b/%b a %h/%h b %h/%h",
                    exp_r.next_addr, got.next_addr, exp_r.next_bank, got.next_bank,
                    exp_r.error_flag, got.error_flag, exp_r.display_on, got.display_on,
                    exp_r.display_strobe, got.display_strobe, exp_r.digits_a, got.digits_a,
                    exp_r.digits_b, got.digits_b);
        end
    endfunction
endclass

module bcd_calculator_instruction_executor_tb;
    localparam int IDLE_LIMIT = 5000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [9:0]  i_instr_word = 0;
    logic        i_key_valid = 0;
    logic [7:0]  i_key_value = 0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [7:0]  o_next_addr;
    logic [2:0]  o_next_bank;
    logic        o_error_flag;
    logic        o_display_on;
    logic        o_display_strobe;
    logic [55:0] o_digits_a;
    logic [55:0] o_digits_b;

    exec_scoreboard exec_sb = new();
    int unsigned idle_cycles = 0;
    int unsigned stall_phase = 0;

    bcd_calculator_instruction_executor i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_instr_word(i_instr_word), .i_key_valid(i_key_valid),
        .i_key_value(i_key_value), .o_valid(o_valid), .i_ready(i_ready),
        .o_next_addr(o_next_addr), .o_next_bank(o_next_bank),
        .o_error_flag(o_error_flag), .o_display_on(o_display_on),
        .o_display_strobe(o_display_strobe), .o_digits_a(o_digits_a),
        .o_digits_b(o_digits_b)
    );

    always #5 i_clk = ~i_clk;

    // Receiver: checks each taken result and steps through four stall patterns.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            exec_sb.check_result({o_next_addr, o_next_bank, o_error_flag, o_display_on,
                                  o_display_strobe, o_digits_a, o_digits_b});
        stall_phase <= stall_phase + 1;
        case ((stall_phase / 64) % 4)
            0: i_ready <= 1'b1;
            1: i_ready <= ($urandom_range(0, 3) != 0);
            2: i_ready <= ($urandom_range(0, 1) != 0);
            default: i_ready <= (stall_phase % 7) < 2;
        endcase
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    int burst_left = 0;

    // Valid stays up after a transfer only when the next word follows at once.
    task automatic send_word(logic [9:0] word, logic kv, logic [7:0] kval);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_instr_word <= word;
        i_key_valid <= kv;
        i_key_value <= kval;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        exec_sb.note_transfer(word, kv, kval);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (exec_sb.pending_q.size() != 0) @(posedge i_clk);
    endtask

    // Mostly plausible words: arithmetic ops, branches, display and stack moves.
    function automatic logic [9:0] pick_word();
        logic [9:0] w;
        w = 10'($urandom_range(0, 1023));
        case ($urandom_range(0, 9))
            0, 1, 2, 3: w[1:0] = 2'b10;
            4: w[5:0] = 6'h18;
            5: w[5:0] = 6'h0C;
            6: w[7:0] = ($urandom_range(0, 1) != 0) ? 8'hA8 : 8'h28;
            7: w[5:0] = 6'h14;
            default: ;
        endcase
        return w;
    endfunction

    initial begin
        logic [9:0] w;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: display toggle on/off, stack moves, keys, pointer beyond last digit.
        send_word(10'h228, 1'b0, 8'h00);
        send_word(10'h3A8, 1'b0, 8'h00);
        send_word(10'h0A8, 1'b0, 8'h00);
        send_word(10'h228, 1'b0, 8'h00);
        send_word(10'h228, 1'b0, 8'h00);
        send_word(10'h028, 1'b1, 8'hFE);
        send_word(10'h0D0, 1'b0, 8'h00);
        send_word(10'h3CC, 1'b0, 8'h00);   // pointer 15
        send_word(10'h3D8, 1'b0, 8'h00);   // constant load past the end
        send_word(10'h3E2, 1'b0, 8'h00);   // INCA on empty pointer field
        send_word(10'h3F2, 1'b0, 8'h00);   // INCA from 0 to pointer
        send_word(10'h3C4, 1'b0, 8'h00);   // status index beyond range
        send_word(10'h3D4, 1'b0, 8'h00);
        send_word(10'h2AE, 1'b0, 8'h00);   // doubling of C, full field
        send_word(10'h2FD, 1'b0, 8'h00);   // call to 191 in bank 0
        send_word(10'h000, 1'b0, 8'h00);   // executes error address
        send_word(10'h000, 1'b1, 8'h55);
        send_word(10'h030, 1'b0, 8'h00);
        send_word(10'h390, 1'b0, 8'h00);   // bank 7
        send_word(10'h010, 1'b0, 8'h00);
        send_word(10'h3FF, 1'b0, 8'h00);
        send_word(10'h034, 1'b0, 8'h00);
        drain_results();

        for (int n = 0; n < 400; n++) begin
            w = pick_word();
            send_word(w, $urandom_range(0, 15) == 0, 8'($urandom_range(0, 254)));
            if (n == 200) drain_results();
        end

        drain_results();
        repeat (40) @(posedge i_clk);
        if (exec_sb.mismatches == 0 && exec_sb.pending_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
